FILE: src/tca_pkg.sv
// ----------------------------------------------------------------------------
// Thrust curve analyzer package
// Shared constants, types and a helper function.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int unsigned MaxCount = 65536;
  localparam int unsigned CntW = $clog2(MaxCount + 1);

  localparam logic [1:0] RegTrigger = 2'd0;
  localparam logic [1:0] RegStop = 2'd1;
  localparam logic [1:0] RegStopTime = 2'd2;

  localparam logic signed [40:0] SumMax = {1'b0, {40{1'b1}}};
  localparam logic signed [40:0] SumMin = {1'b1, {40{1'b0}}};
  localparam logic [43:0] RiseMax = {44{1'b1}};
  localparam logic [19:0] Million = 20'd1000000;
  localparam logic [9:0] Thousand = 10'd1000;

  typedef struct packed {
    logic [31:0] time_us;
    logic signed [23:0] force_req;
    logic last;
  } sample_t;

  typedef struct packed {
    logic [23:0] peak_force;
    logic [23:0] minimum_force;
    logic [23:0] average_force;
    logic [23:0] burn_average_force;
    logic [62:0] impulse;
    logic [43:0] max_rise_rate;
    logic [15:0] ignition_index;
    logic [15:0] peak_index;
    logic [15:0] burn_end_index;
    logic [31:0] duration_us;
    logic [31:0] burn_time_us;
    logic overflowed;
  } result_t;

  function automatic logic signed [40:0] sat_add41(logic signed [40:0] a,
                                                    logic signed [23:0] b);
    logic signed [41:0] s;
    s = 42'(a) + 42'(b);
    if (s > 42'(SumMax)) return SumMax;
    if (s < 42'(SumMin)) return SumMin;
    return s[40:0];
  endfunction

endpackage

FILE: src/thrust_curve_analyzer.sv
// ----------------------------------------------------------------------------
// Thrust curve analyzer
// Summarizes a run of timestamped load-cell samples.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel (time, force and tlast). A two-entry queue
// holds requests while the core works on one sample at a time. Each sample
// passes through the multiply, update and rise states; when the force rises,
// the rise rate goes through the shared 64-step divider. A sample with tlast
// adds two average divisions on the same divider, then presents one summary
// request on the out_ channel, held in an output register until taken. While
// the receiver stalls the core waits, and the queue fills and then deasserts
// in_tready. Reset clears the run state and loads the default thresholds.
// Thresholds must be written through the cfg_ APB port while idle; unenforced.
// ----------------------------------------------------------------------------
module thrust_curve_analyzer
  import tca_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // time_us, force_req
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // peak_force, minimum_force, average_force, burn_average_force, impulse,
  // max_rise_rate, ignition_index, peak_index, burn_end_index, duration_us,
  // burn_time_us, overflowed
  output logic [319:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic signed [23:0] trig_r, stop_r;
  logic [15:0] stime_r;
  sample_t in_s, q_s;
  logic q_valid, q_ready;
  result_t res;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r <= 24'sd5000;
      stop_r <= 24'sd2000;
      stime_r <= 16'd100;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        RegTrigger: trig_r <= cfg_pwdata[23:0];
        RegStop: stop_r <= cfg_pwdata[23:0];
        RegStopTime: stime_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      RegTrigger: cfg_prdata = 32'(trig_r);
      RegStop: cfg_prdata = 32'(stop_r);
      RegStopTime: cfg_prdata = 32'(stime_r);
      default: cfg_prdata = 32'd0;
    endcase
  end

  assign in_s.time_us = in_tdata[31:0];
  assign in_s.force_req = in_tdata[55:32];
  assign in_s.last = in_tlast;

  tca_queue u_q (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_tvalid), .wr_ready(in_tready),
    .wr_data(in_s), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_s)
  );

  tca_core u_core (
    .clk(clk), .rst_n(rst_n), .trigger_force(trig_r), .stop_force(stop_r),
    .dwell_ms(stime_r), .in_valid(q_valid), .in_ready(q_ready),
    .in_data(q_s), .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  assign out_tdata = {4'd0, res.overflowed, res.burn_time_us, res.duration_us,
                      res.burn_end_index, res.peak_index, res.ignition_index,
                      res.max_rise_rate, res.impulse, res.burn_average_force,
                      res.average_force, res.minimum_force, res.peak_force};

endmodule

FILE: src/tca_queue.sv
// ----------------------------------------------------------------------------
// Thrust curve analyzer sample queue
// Two-entry queue that decouples the accepting front from the processing back.
// ----------------------------------------------------------------------------
module tca_queue
  import tca_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  sample_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output sample_t rd_data
);

  sample_t     mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !wr_en) |=> !rd_valid)
    else $error("queue shows data while empty");

endmodule

FILE: src/tca_divider.sv
// ----------------------------------------------------------------------------
// Thrust curve analyzer divider
// Restoring divider, one quotient bit per cycle, unsigned 64 by 32 bits.
// ----------------------------------------------------------------------------
module tca_divider
  import tca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic [32:0] trial;

  assign busy = (cnt_r != 7'd0);
  assign quotient = q_r;
  assign trial = {rem_r[31:0], q_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else if (start) begin
      cnt_r <= 7'd64;
    end else if (busy) begin
      cnt_r <= cnt_r - 7'd1;
    end
    if (start) begin
      q_r <= dividend;
      rem_r <= 33'd0;
      den_r <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
    else $error("divider did not start");

endmodule

FILE: src/tca_core.sv
// ----------------------------------------------------------------------------
// Thrust curve analyzer core
// Processes one sample at a time and builds the run summary.
// ----------------------------------------------------------------------------
module tca_core
  import tca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [23:0] trigger_force,
  input  logic signed [23:0] stop_force,
  input  logic [15:0]        dwell_ms,
  input  logic               in_valid,
  output logic               in_ready,
  input  sample_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_data
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_UPD  = 9'b000000100,
    S_RISE = 9'b000001000,
    S_AVG1 = 9'b000010000,
    S_AVG1W = 9'b000100000,
    S_AVG2 = 9'b001000000,
    S_AVG2W = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r;
  sample_t cur_r;
  logic [CntW-1:0] count_r;
  logic [31:0] first_time_r, prev_time_r, bprev_time_r;
  logic signed [23:0] prev_force_r, bprev_force_r, low_r, high_r;
  logic [CntW-1:0] high_idx_r;
  logic signed [40:0] fsum_r, bsum_r;
  logic [63:0] imp_r;
  logic [43:0] rise_r;
  logic [1:0] trun_r;
  logic ign_r, ended_r, below_v_r, ovf_r;
  logic [CntW-1:0] ign_at_r, end_at_r, bcount_r;
  logic [31:0] ign_time_r, end_time_r, below_since_r;
  logic [56:0] add_r;
  logic [44:0] rnum_r;
  logic [31:0] dt_r;
  logic rise_go_r;
  result_t res_r;
  logic out_valid_r;

  logic div_start, div_busy;
  logic [63:0] div_a, div_q;
  logic [31:0] div_b;
  logic neg_r;
  logic signed [40:0] avg_sum;
  logic [CntW-1:0] avg_cnt;

  tca_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  logic [31:0] dt;
  logic [24:0] ppos;
  logic [23:0] pp, cp;
  logic [31:0] since;
  logic [41:0] stop_us;
  logic [40:0] mag;
  logic signed [64:0] q_s;
  logic [23:0] clamped;
  logic [43:0] rise_num;

  always_comb begin
    dt = cur_r.time_us - prev_time_r;
    pp = (prev_force_r > 0) ? prev_force_r : 24'd0;
    cp = (cur_r.force_req > 0) ? cur_r.force_req : 24'd0;
    ppos = {1'b0, pp} + {1'b0, cp};
    since = cur_r.time_us - below_since_r;
    stop_us = 42'(dwell_ms) * 42'(Thousand);
    avg_sum = (state_r == S_AVG1 || !ign_r) ? fsum_r : bsum_r;
    avg_cnt = (state_r == S_AVG1 || !ign_r) ? count_r : bcount_r;
    mag = avg_sum[40] ? 41'(-avg_sum) : avg_sum;
    rise_num = 44'(rnum_r[23:0]) * 44'(Million);
    div_start = 1'b0;
    div_a = {23'd0, mag};
    div_b = 32'(avg_cnt);
    if (state_r == S_RISE) begin
      div_start = rise_go_r;
      div_a = 64'(rise_num);
      div_b = dt_r;
    end else if (state_r == S_AVG1 || state_r == S_AVG2) begin
      div_start = 1'b1;
    end
    q_s = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (q_s > 65'sd8388607) clamped = 24'h7fffff;
    else if (q_s < -65'sd8388608) clamped = 24'h800000;
    else clamped = q_s[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r <= '0;
      ovf_r <= 1'b0;
      ign_r <= 1'b0;
      ended_r <= 1'b0;
      below_v_r <= 1'b0;
      trun_r <= 2'd0;
      fsum_r <= '0; bsum_r <= '0; imp_r <= '0; rise_r <= '0;
      first_time_r <= '0; prev_time_r <= '0; bprev_time_r <= '0;
      prev_force_r <= '0; bprev_force_r <= '0; low_r <= '0; high_r <= '0;
      high_idx_r <= '0; ign_at_r <= '0; end_at_r <= '0; bcount_r <= '0;
      ign_time_r <= '0; end_time_r <= '0; below_since_r <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_r <= in_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          add_r <= 57'(ppos) * 57'(dt);
          dt_r <= dt;
          rnum_r <= 45'(cur_r.force_req) - 45'(prev_force_r);
          rise_go_r <= 1'b0;
          if (count_r >= CntW'(MaxCount)) begin
            ovf_r <= 1'b1;
            state_r <= cur_r.last ? S_AVG1 : S_IDLE;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if ((count_r != '0) && (dt_r != 0) && (cur_r.force_req > prev_force_r)) begin
            rise_go_r <= 1'b1;
          end else begin
            rise_go_r <= 1'b0;
            rnum_r <= '0;
          end
          if (count_r == '0) begin
            first_time_r <= cur_r.time_us;
            low_r <= cur_r.force_req;
            high_r <= cur_r.force_req;
            high_idx_r <= '0;
            fsum_r <= 41'(cur_r.force_req);
            trun_r <= (cur_r.force_req >= trigger_force) ? 2'd1 : 2'd0;
          end else begin
            if (cur_r.force_req < low_r) low_r <= cur_r.force_req;
            if (cur_r.force_req > high_r) begin
              high_r <= cur_r.force_req;
              high_idx_r <= count_r;
            end
            fsum_r <= sat_add41(fsum_r, cur_r.force_req);
            if (dt_r != 0) begin
              imp_r <= (imp_r > ~64'(add_r)) ? {64{1'b1}} : imp_r + 64'(add_r);
            end
            if (!ign_r) begin
              if (cur_r.force_req >= trigger_force) begin
                if (trun_r == 2'd2 || trun_r == 2'd3) begin
                  trun_r <= 2'd3;
                  ign_r <= 1'b1;
                  ign_at_r <= count_r - CntW'(2);
                  ign_time_r <= bprev_time_r;
                  bsum_r <= 41'(bprev_force_r) + 41'(prev_force_r) + 41'(cur_r.force_req);
                  bcount_r <= CntW'(3);
                end else begin
                  trun_r <= trun_r + 2'd1;
                end
              end else begin
                trun_r <= 2'd0;
              end
            end else if (!ended_r) begin
              bsum_r <= sat_add41(bsum_r, cur_r.force_req);
              bcount_r <= bcount_r + CntW'(1);
              if (cur_r.force_req <= stop_force) begin
                if (!below_v_r) begin
                  below_v_r <= 1'b1;
                  below_since_r <= cur_r.time_us;
                end
                if ((below_v_r ? 42'(since) : 42'd0) >= stop_us) begin
                  ended_r <= 1'b1;
                  end_at_r <= count_r;
                  end_time_r <= cur_r.time_us;
                end
              end else begin
                below_v_r <= 1'b0;
              end
            end
          end
          bprev_force_r <= prev_force_r;
          prev_force_r <= cur_r.force_req;
          bprev_time_r <= prev_time_r;
          prev_time_r <= cur_r.time_us;
          count_r <= count_r + CntW'(1);
          state_r <= S_RISE;
        end
        S_RISE: begin
          if (rise_go_r) begin
            rise_go_r <= 1'b0;
          end else if (!div_busy) begin
            if (rnum_r != '0 && dt_r != 0 && div_q[63:44] == '0 && div_q[43:0] > rise_r)
              rise_r <= div_q[43:0];
            else if (rnum_r != '0 && dt_r != 0 && div_q[63:44] != '0)
              rise_r <= RiseMax;
            rnum_r <= '0;
            state_r <= cur_r.last ? S_AVG1 : S_IDLE;
          end
        end
        S_AVG1: begin
          neg_r <= fsum_r[40];
          state_r <= S_AVG1W;
        end
        S_AVG1W: begin
          if (!div_busy) begin
            res_r.average_force <= (count_r == '0) ? 24'd0 : clamped;
            state_r <= S_AVG2;
          end
        end
        S_AVG2: begin
          neg_r <= ign_r ? bsum_r[40] : fsum_r[40];
          state_r <= S_AVG2W;
        end
        S_AVG2W: begin
          if (!div_busy) begin
            res_r.burn_average_force <= (count_r == '0) ? 24'd0 : clamped;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          res_r.peak_force <= high_r;
          res_r.minimum_force <= low_r;
          res_r.impulse <= imp_r[63:1];
          res_r.max_rise_rate <= rise_r;
          res_r.ignition_index <= ign_r ? ign_at_r[15:0] : 16'd0;
          res_r.peak_index <= high_idx_r[15:0];
          res_r.burn_end_index <= (count_r == '0) ? 16'd0 :
                                  ended_r ? end_at_r[15:0] : 16'(count_r - CntW'(1));
          res_r.duration_us <= (count_r != '0 && prev_time_r >= first_time_r) ?
                               prev_time_r - first_time_r : 32'd0;
          res_r.burn_time_us <= (count_r == '0) ? 32'd0 :
            ((ended_r ? end_time_r : prev_time_r) >= (ign_r ? ign_time_r : first_time_r)) ?
            (ended_r ? end_time_r : prev_time_r) - (ign_r ? ign_time_r : first_time_r) :
            32'd0;
          res_r.overflowed <= ovf_r;
          out_valid_r <= 1'b1;
          count_r <= '0; ovf_r <= 1'b0; ign_r <= 1'b0; ended_r <= 1'b0;
          below_v_r <= 1'b0; trun_r <= 2'd0;
          fsum_r <= '0; bsum_r <= '0; imp_r <= '0; rise_r <= '0;
          first_time_r <= '0; prev_time_r <= '0; bprev_time_r <= '0;
          prev_force_r <= '0; bprev_force_r <= '0; low_r <= '0; high_r <= '0;
          high_idx_r <= '0; ign_at_r <= '0; end_at_r <= '0; bcount_r <= '0;
          ign_time_r <= '0; end_time_r <= '0; below_since_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid_r)
    else $error("summary not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(res_r))
    else $error("summary changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> ign_r)
    else $error("burn end without ignition");

endmodule

FILE: dv/tb_thrust_curve_analyzer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thrust curve analyzer testbench
// Drives runs of timestamped force samples into the block and checks every
// summary request against an in-bench model of the run statistics. Directed
// runs come first, then shaped burn curves and noise. The thresholds are
// changed between phases, and both sides idle at random in the first two.
// ----------------------------------------------------------------------------
module tb_thrust_curve_analyzer;
  import tca_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 300;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [319:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  thrust_curve_analyzer u_top (.*);

  sample_t     sample_q[$];
  result_t     summary_q[$];
  int unsigned idle_mode;
  int unsigned mismatches;
  int unsigned cycles;
  bit          in_took;
  int unsigned tnow;

  // Thresholds as the block holds them.
  longint      thr_trig, thr_stop;
  int unsigned thr_dwell_ms;

  // Per-run statistics.
  int unsigned n_samp, t_first, t_prev, t_prev2, hi_idx, trig_run;
  longint      f_prev, f_prev2, f_lo, f_hi, sum_all, sum_burn;
  bit [63:0]   imp_twice, best_rise;
  bit          ign, ended, below_ok, ovf;
  int unsigned ign_at, ign_t, end_at, end_t, below_t, burn_n;

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  function automatic longint sat41(longint s);
    if (s > 64'sd1099511627775) return 64'sd1099511627775;
    if (s < -64'sd1099511627776) return -64'sd1099511627776;
    return s;
  endfunction

  function automatic logic [23:0] mean24(longint s, int unsigned n);
    longint q;
    if (n == 0) return 24'd0;
    q = s / longint'(n);
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return 24'(q);
  endfunction

  task automatic clear_stats();
    n_samp = 0; t_first = 0; t_prev = 0; t_prev2 = 0; hi_idx = 0; trig_run = 0;
    f_prev = 0; f_prev2 = 0; f_lo = 0; f_hi = 0; sum_all = 0; sum_burn = 0;
    imp_twice = 0; best_rise = 0; ign = 0; ended = 0; below_ok = 0; ovf = 0;
    ign_at = 0; ign_t = 0; end_at = 0; end_t = 0; below_t = 0; burn_n = 0;
  endtask

  task automatic fold_sample(input int unsigned t, input longint f, input bit lst);
    int unsigned dt, i, t_ign, t_end;
    bit [63:0]   pp, cp, add, rate;
    result_t     r;
    i = n_samp;
    if (n_samp >= MaxCount) begin
      ovf = 1'b1;
    end else begin
      if (i == 0) begin
        t_first = t; f_lo = f; f_hi = f; hi_idx = 0; sum_all = f;
        trig_run = (f >= thr_trig) ? 1 : 0;
      end else begin
        dt = t - t_prev;
        if (f < f_lo) f_lo = f;
        if (f > f_hi) begin
          f_hi = f; hi_idx = i;
        end
        sum_all = sat41(sum_all + f);
        if (dt != 0) begin
          pp = (f_prev > 0) ? 64'(f_prev) : 64'd0;
          cp = (f > 0) ? 64'(f) : 64'd0;
          add = (pp + cp) * 64'(dt);
          imp_twice = (imp_twice > ~add) ? {64{1'b1}} : imp_twice + add;
          if (f > f_prev) begin
            rate = 64'(f - f_prev) * 64'd1000000 / 64'(dt);
            if (rate > 64'(RiseMax)) rate = 64'(RiseMax);
            if (rate > best_rise) best_rise = rate;
          end
        end
        if (!ign) begin
          if (f >= thr_trig) begin
            if (trig_run < 3) trig_run++;
            if (trig_run >= 3) begin
              ign = 1'b1; ign_at = i - 2; ign_t = t_prev2;
              sum_burn = f_prev2 + f_prev + f; burn_n = 3;
            end
          end else begin
            trig_run = 0;
          end
        end else if (!ended) begin
          sum_burn = sat41(sum_burn + f);
          burn_n++;
          if (f <= thr_stop) begin
            if (!below_ok) begin
              below_ok = 1'b1; below_t = t;
            end
            if (t - below_t >= thr_dwell_ms * 1000) begin
              ended = 1'b1; end_at = i; end_t = t;
            end
          end else begin
            below_ok = 1'b0;
          end
        end
      end
      f_prev2 = f_prev; f_prev = f; t_prev2 = t_prev; t_prev = t;
      n_samp = i + 1;
    end
    if (lst) begin
      r = '0;
      t_ign = ign ? ign_t : t_first;
      t_end = ended ? end_t : t_prev;
      r.peak_force = 24'(f_hi);
      r.minimum_force = 24'(f_lo);
      r.average_force = mean24(sum_all, n_samp);
      r.burn_average_force = ign ? mean24(sum_burn, burn_n) : mean24(sum_all, n_samp);
      r.impulse = 63'(imp_twice >> 1);
      r.max_rise_rate = 44'(best_rise);
      r.ignition_index = ign ? 16'(ign_at) : 16'd0;
      r.peak_index = 16'(hi_idx);
      r.burn_end_index = ended ? 16'(end_at) : 16'(n_samp - 1);
      r.duration_us = (t_prev >= t_first) ? t_prev - t_first : 32'd0;
      r.burn_time_us = (t_end >= t_ign) ? t_end - t_ign : 32'd0;
      r.overflowed = ovf;
      summary_q.push_back(r);
      clear_stats();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s: expected %h, got %h", name, exp_v, got_v);
    end
  endtask

  // Stimulus driver.
  always @(negedge clk) begin
    if (!in_tvalid || in_took) begin
      if (sample_q.size() != 0 &&
          !(idle_mode == 0 && $urandom_range(0, 99) < 31) &&
          !(idle_mode == 1 && $urandom_range(0, 99) < 61)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {sample_q[0].force_req, sample_q[0].time_us};
        in_tlast <= sample_q[0].last;
        void'(sample_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    case (idle_mode)
      0: out_tready <= ($urandom_range(0, 99) >= 61);
      1: out_tready <= ($urandom_range(0, 99) >= 31);
      default: out_tready <= 1'b1;
    endcase
  end

  // Request monitor and summary checker.
  always @(posedge clk) begin
    result_t exp_r;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      fold_sample(in_tdata[31:0], longint'($signed(in_tdata[55:32])), in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected summary request: %h", out_tdata);
      end else begin
        exp_r = summary_q.pop_front();
        check_field("peak_force", exp_r.peak_force, out_tdata[23:0]);
        check_field("minimum_force", exp_r.minimum_force, out_tdata[47:24]);
        check_field("average_force", exp_r.average_force, out_tdata[71:48]);
        check_field("burn_average_force", exp_r.burn_average_force, out_tdata[95:72]);
        check_field("impulse", exp_r.impulse, out_tdata[158:96]);
        check_field("max_rise_rate", exp_r.max_rise_rate, out_tdata[202:159]);
        check_field("ignition_index", exp_r.ignition_index, out_tdata[218:203]);
        check_field("peak_index", exp_r.peak_index, out_tdata[234:219]);
        check_field("burn_end_index", exp_r.burn_end_index, out_tdata[250:235]);
        check_field("duration_us", exp_r.duration_us, out_tdata[282:251]);
        check_field("burn_time_us", exp_r.burn_time_us, out_tdata[314:283]);
        check_field("overflowed", exp_r.overflowed, out_tdata[315]);
      end
    end
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return 24'(v);
  endfunction

  task automatic push_sample(input int unsigned t, input longint f, input bit lst);
    sample_t s;
    s.time_us = t;
    s.force_req = clamp24(f);
    s.last = lst;
    sample_q.push_back(s);
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_tvalid || summary_q.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      RegTrigger: thr_trig = longint'($signed(val[23:0]));
      RegStop: thr_stop = longint'($signed(val[23:0]));
      default: thr_dwell_ms = val[15:0];
    endcase
  endtask

  task automatic set_thresholds(input longint trig, input longint stp,
                                input int unsigned dwell);
    wait_idle();
    write_reg(RegTrigger, 32'(trig));
    write_reg(RegStop, 32'(stp));
    write_reg(RegStopTime, 32'(dwell));
  endtask

  function automatic int unsigned next_step();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(20000, 60000);
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  // Adds one run and returns the number of samples in it.
  task automatic add_run(output int unsigned n);
    int unsigned n_pre, n_burn, n_tail, k;
    longint      f;
    if ($urandom_range(0, 9) < 7) begin
      n_pre = $urandom_range(0, 4);
      n_burn = $urandom_range(1, 12);
      n_tail = $urandom_range(0, 10);
      n = n_pre + n_burn + n_tail;
      if ($urandom_range(0, 7) == 0) tnow = $urandom;
      for (k = 0; k < n; k++) begin
        if (k < n_pre) f = thr_trig - $urandom_range(1, 3000);
        else if (k < n_pre + n_burn)
          f = ($urandom_range(0, 7) == 0) ? thr_trig - 1 : thr_trig + $urandom_range(0, 200000);
        else
          f = ($urandom_range(0, 7) == 0) ? thr_stop + 1 : thr_stop - $urandom_range(0, 2000);
        push_sample(tnow, f, k == n - 1);
        tnow += next_step();
      end
    end else begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
        push_sample($urandom, longint'($signed(24'($urandom))), k == n - 1);
    end
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned done, n;
    done = 0;
    while (done < items) begin
      add_run(n);
      done += n;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_took = 1'b0;
    idle_mode = 0;
    mismatches = 0;
    cycles = 0;
    tnow = 1000;
    thr_trig = 5000;
    thr_stop = 2000;
    thr_dwell_ms = 100;
    clear_stats();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed runs at the reset thresholds.
    push_sample(0, -8388608, 1'b1);
    push_sample(0, 8388607, 1'b0);
    push_sample(0, 8388607, 1'b0);
    push_sample(100, -8388608, 1'b0);
    push_sample(32'hFFFF_FFFF, 0, 1'b1);
    push_sample(1000, 100, 1'b0);
    push_sample(2000, 6000, 1'b0);
    push_sample(3000, 6000, 1'b0);
    push_sample(3000, 6000, 1'b0);
    push_sample(4000, 7000, 1'b0);
    push_sample(5000, 1500, 1'b0);
    push_sample(50000, 1500, 1'b0);
    push_sample(105000, 2000, 1'b0);
    push_sample(106000, 9000, 1'b1);
    push_sample(32'hFFFF_FF00, 8388607, 1'b0);
    push_sample(32'h0000_0100, 8388607, 1'b0);
    push_sample(32'h0000_0100, -8388608, 1'b0);
    push_sample(32'h0000_0101, 8388607, 1'b1);
    random_phase(160);

    idle_mode = 1;
    set_thresholds(-8388608, 8388607, 0);
    random_phase(170);

    idle_mode = 2;
    set_thresholds(8388607, -8388608, 65535);
    random_phase(170);

    set_thresholds(3000, 500, 20);
    random_phase(180);

    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
